[rtl/bsp_pkg.sv]
package bsp_pkg;

  localparam int CW          = 33;
  localparam int IN_TDATA_W  = 256;
  localparam int IN_TUSER_W  = 6;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 5;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int PS_W        = 16;
  localparam int THR_W       = PS_W + 1;
  localparam int FW          = 16;

  localparam logic [PS_W-1:0] PIXEL_SIZE_RST = 16'd15;
  localparam logic            REG_PIXEL_SIZE = 1'b0;

  localparam logic [FW-1:0] F_HALF  = 16'd32768;
  localparam logic [FW-1:0] F_THIRD = 16'd21845;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  localparam logic [1:0] SHADE_BASE  = 2'd0;
  localparam logic [1:0] SHADE_LIGHT = 2'd1;
  localparam logic [1:0] SHADE_DARK  = 2'd2;

  typedef enum logic [3:0] {
    STY_NONE   = 4'd0,
    STY_HIDDEN = 4'd1,
    STY_DOTTED = 4'd2,
    STY_DASHED = 4'd3,
    STY_SOLID  = 4'd4,
    STY_DOUBLE = 4'd5,
    STY_GROOVE = 4'd6,
    STY_RIDGE  = 4'd7,
    STY_INSET  = 4'd8,
    STY_OUTSET = 4'd9
  } style_t;

  typedef enum logic [1:0] {
    PART_FULL = 2'd0,
    PART_IN   = 2'd1,
    PART_OUT  = 2'd2
  } part_t;

  // vertex coordinate source: outer edge, inner edge, or blend of the two
  typedef enum logic [1:0] {
    SRC_O = 2'd0,
    SRC_I = 2'd1,
    SRC_B = 2'd2
  } src_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [1:0] side;
    logic       split;
    logic       thick;
    logic       third;
    logic [1:0] shade0;
    logic [1:0] shade1;
    coord_t     ox;
    coord_t     oy;
    coord_t     oxm;
    coord_t     oym;
    coord_t     ix;
    coord_t     iy;
    coord_t     ixm;
    coord_t     iym;
  } item_t;

  typedef struct packed {
    logic x_hi;
    src_t x_src;
    logic y_hi;
    src_t y_src;
  } vspec_t;

  function automatic logic [1:0] bevel(logic [1:0] side, logic flip);
    logic dark;
    dark = (side == SIDE_RIGHT || side == SIDE_BOTTOM) ^ flip;
    return dark ? SHADE_DARK : SHADE_LIGHT;
  endfunction

  function automatic vspec_t mk(logic xh, src_t xs, logic yh, src_t ys);
    vspec_t v;
    v.x_hi  = xh;
    v.x_src = xs;
    v.y_hi  = yh;
    v.y_src = ys;
    return v;
  endfunction

  // x_hi selects x+width, y_hi selects y+height
  function automatic vspec_t vtx_spec(logic [1:0] side, part_t part, logic [1:0] idx,
                                      logic thick);
    vspec_t     v;
    logic [1:0] k;
    k = idx;
    v = mk(1'b0, SRC_O, 1'b0, SRC_O);
    if (part == PART_FULL && !thick) begin
      case (side)
        SIDE_LEFT:  k = {idx[0], idx[0]};
        SIDE_RIGHT: k = {1'b1, idx[0]};
        default:    k = idx;
      endcase
    end
    case (side)
      SIDE_TOP: begin
        case (part)
          PART_FULL: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b0, SRC_O);
              2'd1:    v = mk(1'b1, SRC_O, 1'b0, SRC_O);
              2'd2:    v = mk(1'b1, SRC_I, 1'b0, SRC_I);
              default: v = mk(1'b0, SRC_I, 1'b0, SRC_I);
            endcase
          end
          PART_IN: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_B, 1'b0, SRC_B);
              2'd1:    v = mk(1'b1, SRC_B, 1'b0, SRC_B);
              2'd2:    v = mk(1'b1, SRC_I, 1'b0, SRC_I);
              default: v = mk(1'b0, SRC_I, 1'b0, SRC_I);
            endcase
          end
          default: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b0, SRC_O);
              2'd1:    v = mk(1'b1, SRC_O, 1'b0, SRC_O);
              2'd2:    v = mk(1'b1, SRC_B, 1'b0, SRC_B);
              default: v = mk(1'b0, SRC_B, 1'b0, SRC_B);
            endcase
          end
        endcase
      end
      SIDE_LEFT: begin
        case (part)
          PART_FULL: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b0, SRC_O);
              2'd1:    v = mk(1'b0, SRC_I, 1'b0, SRC_I);
              2'd2:    v = mk(1'b0, SRC_I, 1'b1, SRC_I);
              default: v = mk(1'b0, SRC_O, 1'b1, SRC_O);
            endcase
          end
          PART_IN: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_B, 1'b0, SRC_B);
              2'd1:    v = mk(1'b0, SRC_I, 1'b0, SRC_I);
              2'd2:    v = mk(1'b0, SRC_I, 1'b1, SRC_I);
              default: v = mk(1'b0, SRC_B, 1'b1, SRC_B);
            endcase
          end
          default: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b0, SRC_O);
              2'd1:    v = mk(1'b0, SRC_B, 1'b0, SRC_B);
              2'd2:    v = mk(1'b0, SRC_B, 1'b1, SRC_B);
              default: v = mk(1'b0, SRC_O, 1'b1, SRC_O);
            endcase
          end
        endcase
      end
      SIDE_BOTTOM: begin
        case (part)
          PART_FULL: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b1, SRC_O);
              2'd1:    v = mk(1'b0, SRC_I, 1'b1, SRC_I);
              2'd2:    v = mk(1'b1, SRC_I, 1'b1, SRC_I);
              default: v = mk(1'b1, SRC_O, 1'b1, SRC_O);
            endcase
          end
          PART_IN: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_B, 1'b1, SRC_B);
              2'd1:    v = mk(1'b0, SRC_I, 1'b1, SRC_I);
              2'd2:    v = mk(1'b1, SRC_I, 1'b1, SRC_I);
              default: v = mk(1'b1, SRC_B, 1'b1, SRC_B);
            endcase
          end
          default: begin
            case (k)
              2'd0:    v = mk(1'b0, SRC_O, 1'b1, SRC_O);
              2'd1:    v = mk(1'b0, SRC_B, 1'b1, SRC_B);
              2'd2:    v = mk(1'b1, SRC_B, 1'b1, SRC_B);
              default: v = mk(1'b1, SRC_O, 1'b1, SRC_O);
            endcase
          end
        endcase
        // thin bottom line runs along the inner bottom edge
        if (part == PART_FULL && !thick) begin
          v = mk(idx[0], SRC_O, 1'b1, SRC_I);
        end
      end
      default: begin
        case (part)
          PART_FULL: begin
            case (k)
              2'd0:    v = mk(1'b1, SRC_O, 1'b1, SRC_O);
              2'd1:    v = mk(1'b1, SRC_O, 1'b0, SRC_O);
              2'd2:    v = mk(1'b1, SRC_I, 1'b0, SRC_I);
              default: v = mk(1'b1, SRC_I, 1'b1, SRC_I);
            endcase
          end
          PART_IN: begin
            case (k)
              2'd0:    v = mk(1'b1, SRC_I, 1'b0, SRC_I);
              2'd1:    v = mk(1'b1, SRC_B, 1'b0, SRC_B);
              2'd2:    v = mk(1'b1, SRC_B, 1'b1, SRC_B);
              default: v = mk(1'b1, SRC_I, 1'b1, SRC_I);
            endcase
          end
          default: begin
            case (k)
              2'd0:    v = mk(1'b1, SRC_B, 1'b0, SRC_B);
              2'd1:    v = mk(1'b1, SRC_O, 1'b0, SRC_O);
              2'd2:    v = mk(1'b1, SRC_O, 1'b1, SRC_O);
              default: v = mk(1'b1, SRC_B, 1'b1, SRC_B);
            endcase
          end
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

[rtl/border_side_polygon.sv]
// Request path: front register, queue, back-end stages b, c and d, output register.
// The back end gives one vertex per cycle while a request is queued and the output is
// not stalled: 8 vertices for groove, ridge and double, 4 for a full side, 2 for a
// thin line. Requests that draw nothing are dropped; a 2-entry queue decouples stalls.
// Reset (synchronous, rst_n low) empties all stages and sets pixel_size to 15.
module border_side_polygon import bsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // outer_x, outer_y, outer_width, outer_height,
  // inner_x, inner_y, inner_width, inner_height, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // side, style
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vertex_x, vertex_y, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // polygon_index, shade, draw_as_line, polygon_end
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [PS_W-1:0]  pixel_size_r;
  logic [THR_W-1:0] thr;
  logic             q_push, q_ready, q_pop, q_valid;
  item_t            q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_PIXEL_SIZE) ?
                      {{(CFG_DW-PS_W){1'b0}}, pixel_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_size_r <= PIXEL_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_PIXEL_SIZE) begin
      pixel_size_r <= cfg_pwdata[PS_W-1:0];
    end
  end

  // thin-line threshold: 1.25 pixels
  assign thr = {1'b0, pixel_size_r} + {3'b000, pixel_size_r[PS_W-1:2]};

  bsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .thr       (thr),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bsp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  bsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/bsp_front.sv]
module bsp_front import bsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // outer_x, outer_y, outer_width, outer_height,
  // inner_x, inner_y, inner_width, inner_height, zero pad
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // side, style
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic [THR_W-1:0]      thr,
  input  logic                  q_ready,
  output logic                  q_push,
  output item_t                 q_wdata
);

  logic       s1_valid_r;
  logic [1:0] side_r;
  style_t     style_r;
  coord_t     ox_r, oy_r, oxm_r, oym_r, ix_r, iy_r, ixm_r, iym_r;

  logic              draws;
  logic              consume;
  coord_t            tp, tm;
  logic signed [CW:0] diff;
  logic              thick;

  always_comb begin
    case (style_r)
      STY_SOLID, STY_DOUBLE, STY_GROOVE, STY_RIDGE, STY_INSET, STY_OUTSET: draws = 1'b1;
      default:                                                         draws = 1'b0;
    endcase
  end

  assign consume   = s1_valid_r && (q_ready || !draws);
  assign in_tready = !s1_valid_r || consume;
  assign q_push    = s1_valid_r && draws && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      side_r  <= in_tuser[1:0];
      style_r <= style_t'(in_tuser[5:2]);
      ox_r    <= {in_tdata[31], in_tdata[31:0]};
      oy_r    <= {in_tdata[63], in_tdata[63:32]};
      oxm_r   <= {in_tdata[31], in_tdata[31:0]} + {2'b00, in_tdata[94:64]};
      oym_r   <= {in_tdata[63], in_tdata[63:32]} + {2'b00, in_tdata[125:95]};
      ix_r    <= {in_tdata[157], in_tdata[157:126]};
      iy_r    <= {in_tdata[189], in_tdata[189:158]};
      ixm_r   <= {in_tdata[157], in_tdata[157:126]} + {2'b00, in_tdata[220:190]};
      iym_r   <= {in_tdata[189], in_tdata[189:158]} + {2'b00, in_tdata[251:221]};
    end
  end

  // side thickness against the thin-line threshold
  always_comb begin
    case (side_r)
      SIDE_TOP: begin
        tp = iy_r;
        tm = oy_r;
      end
      SIDE_LEFT: begin
        tp = ix_r;
        tm = ox_r;
      end
      SIDE_BOTTOM: begin
        tp = oym_r;
        tm = iym_r;
      end
      default: begin
        tp = oxm_r;
        tm = ixm_r;
      end
    endcase
    diff  = {tp[CW-1], tp} - {tm[CW-1], tm};
    thick = diff >= $signed({{(CW+1-THR_W){1'b0}}, thr});
  end

  always_comb begin
    q_wdata.side   = side_r;
    q_wdata.split  = 1'b0;
    q_wdata.thick  = thick;
    q_wdata.third  = 1'b0;
    q_wdata.shade0 = SHADE_BASE;
    q_wdata.shade1 = SHADE_BASE;
    q_wdata.ox     = ox_r;
    q_wdata.oy     = oy_r;
    q_wdata.oxm    = oxm_r;
    q_wdata.oym    = oym_r;
    q_wdata.ix     = ix_r;
    q_wdata.iy     = iy_r;
    q_wdata.ixm    = ixm_r;
    q_wdata.iym    = iym_r;
    case (style_r)
      STY_INSET:  q_wdata.shade0 = bevel(side_r, 1'b0);
      STY_OUTSET: q_wdata.shade0 = bevel(side_r, 1'b1);
      STY_DOUBLE: begin
        q_wdata.split = 1'b1;
        q_wdata.third = 1'b1;
      end
      STY_GROOVE: begin
        q_wdata.split  = 1'b1;
        q_wdata.shade0 = bevel(side_r, 1'b0);
        q_wdata.shade1 = bevel(side_r, 1'b1);
      end
      STY_RIDGE: begin
        q_wdata.split  = 1'b1;
        q_wdata.shade0 = bevel(side_r, 1'b1);
        q_wdata.shade1 = bevel(side_r, 1'b0);
      end
      default: q_wdata.split = 1'b0;
    endcase
  end

endmodule

[rtl/bsp_queue.sv]
module bsp_queue import bsp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t rdata
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] count_r, count_nxt;

  assign ready = (count_r != 2'd2);
  assign valid = (count_r != 2'd0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2) || pop)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("request queue underflow");

endmodule

[rtl/bsp_back.sv]
module bsp_back import bsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  item_t                  q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vertex_x, vertex_y, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // polygon_index, shade, draw_as_line, polygon_end
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  typedef struct packed {
    logic       poly;
    logic [1:0] shade;
    logic       dal;
    logic       pend;
    logic       last;
  } meta_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
  } pair_t;

  function automatic pair_t pick(src_t s, coord_t o, coord_t i, logic out_part);
    pair_t p;
    case (s)
      SRC_I: begin
        p.a = i;
        p.b = i;
      end
      SRC_B: begin
        p.a = out_part ? i : o;
        p.b = out_part ? o : i;
      end
      default: begin
        p.a = o;
        p.b = o;
      end
    endcase
    return p;
  endfunction

  logic [2:0] cnt_r, cnt_nxt;
  logic       en, issue;
  part_t      part;
  logic [1:0] idx;
  logic       two, last_v;
  vspec_t     spec;
  pair_t      px_ab, py_ab;
  meta_t      meta;

  logic                 vb_r, vc_r, vd_r, out_valid_r;
  coord_t               bx_b_r, by_b_r, bx_c_r, by_c_r;
  logic signed [CW:0]   dx_b_r, dy_b_r;
  logic [FW-1:0]        f_b_r;
  meta_t                meta_b_r, meta_c_r, meta_d_r, meta_o_r;
  logic signed [CW+FW+1:0] mx, my, px_c_r, py_c_r;
  logic signed [CW+1:0] rx, ry, rx_d_r, ry_d_r;
  logic                 fx, fy, fx_d_r, fy_d_r;
  logic signed [CW+1:0] sx, sy;
  coord_t               vx_r, vy_r;

  assign en    = !out_valid_r || out_tready;
  assign issue = en && q_valid;
  assign q_pop = issue && last_v;

  // sequencer: one vertex a cycle from the head request while the output is not stalled
  always_comb begin
    idx    = cnt_r[1:0];
    part   = !q_data.split ? PART_FULL : (cnt_r[2] ? PART_OUT : PART_IN);
    two    = !q_data.split && !q_data.thick;
    last_v = q_data.split ? (cnt_r == 3'd7) : (two ? (idx == 2'd1) : (idx == 2'd3));
    spec   = vtx_spec(q_data.side, part, idx, q_data.thick);
    px_ab  = pick(spec.x_src, spec.x_hi ? q_data.oxm : q_data.ox,
                  spec.x_hi ? q_data.ixm : q_data.ix, part == PART_OUT);
    py_ab  = pick(spec.y_src, spec.y_hi ? q_data.oym : q_data.oy,
                  spec.y_hi ? q_data.iym : q_data.iy, part == PART_OUT);
    meta.poly  = (part == PART_OUT);
    meta.shade = (part == PART_OUT) ? q_data.shade1 : q_data.shade0;
    meta.dal   = two;
    meta.pend  = two ? (idx == 2'd1) : (idx == 2'd3);
    meta.last  = last_v;
    cnt_nxt    = q_pop ? 3'd0 : cnt_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      if (issue) begin
        cnt_r <= cnt_nxt;
      end
      vb_r        <= issue;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      out_valid_r <= vd_r;
    end
  end

  // (a*F + b*(1-F)) = b + (a-b)*F, quotient truncated toward zero
  always_comb begin
    mx = dx_b_r * $signed({1'b0, f_b_r});
    my = dy_b_r * $signed({1'b0, f_b_r});
    rx = {{2{bx_c_r[CW-1]}}, bx_c_r} + px_c_r[CW+FW+1:FW];
    ry = {{2{by_c_r[CW-1]}}, by_c_r} + py_c_r[CW+FW+1:FW];
    fx = rx[CW+1] && (px_c_r[FW-1:0] != '0);
    fy = ry[CW+1] && (py_c_r[FW-1:0] != '0);
    sx = rx_d_r + {{(CW+1){1'b0}}, fx_d_r};
    sy = ry_d_r + {{(CW+1){1'b0}}, fy_d_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx_b_r   <= px_ab.b;
      by_b_r   <= py_ab.b;
      dx_b_r   <= {px_ab.a[CW-1], px_ab.a} - {px_ab.b[CW-1], px_ab.b};
      dy_b_r   <= {py_ab.a[CW-1], py_ab.a} - {py_ab.b[CW-1], py_ab.b};
      f_b_r    <= q_data.third ? F_THIRD : F_HALF;
      meta_b_r <= meta;
      bx_c_r   <= bx_b_r;
      by_c_r   <= by_b_r;
      px_c_r   <= mx;
      py_c_r   <= my;
      meta_c_r <= meta_b_r;
      rx_d_r   <= rx;
      ry_d_r   <= ry;
      fx_d_r   <= fx;
      fy_d_r   <= fy;
      meta_d_r <= meta_c_r;
      vx_r     <= sx[CW-1:0];
      vy_r     <= sy[CW-1:0];
      meta_o_r <= meta_d_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*CW){1'b0}}, vy_r, vx_r};
  assign out_tuser  = {meta_o_r.pend, meta_o_r.dal, meta_o_r.shade, meta_o_r.poly};
  assign out_tlast  = meta_o_r.last;

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_data.split) |-> !cnt_r[2])
    else $error("single polygon request ran past four vertices");

  a_last_ends_poly: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && meta_o_r.last) |-> meta_o_r.pend)
    else $error("last vertex does not close its polygon");

  a_line_first_poly: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && meta_o_r.dal) |-> (!meta_o_r.poly && meta_o_r.shade != SHADE_DARK + 2'd1))
    else $error("line vertex on second polygon");

endmodule
